### src/nbsp_pkg.sv
// Shared types and constants of the n-bit sample packer.
`default_nettype none

package nbsp_pkg;

  localparam int CODE_W  = 15;
  localparam int BEAT_W  = 8;

  // Input item kinds, carried on in_tuser.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TABLE  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Packing modes.
  localparam logic [1:0] MODE_COPY  = 2'd0;
  localparam logic [1:0] MODE_SHIFT = 2'd1;
  localparam logic [1:0] MODE_TABLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PACK_MODE   = 3'd0;
  localparam logic [2:0] REG_SAMPLE_BITS = 3'd1;
  localparam logic [2:0] REG_CODE_BITS   = 3'd2;
  localparam logic [2:0] REG_OFFSET      = 3'd3;
  localparam logic [2:0] REG_TABLE_COUNT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CODE,
    ST_SEARCH,
    ST_PACK
  } nbsp_state_t;

  // Command into the bit packer.
  typedef struct packed {
    logic              pack_en;
    logic              flush_en;
    logic [CODE_W-1:0] code;
    logic [3:0]        code_bits;
  } nbsp_pack_cmd_t;

  // What the bit packer produces in the current cycle.
  typedef struct packed {
    logic [1:0]        n_bytes;
    logic [BEAT_W-1:0] byte0;
    logic [BEAT_W-1:0] byte1;
    logic              flush_valid;
    logic [BEAT_W-1:0] flush_byte;
  } nbsp_pack_res_t;

  // One result beat as queued for the output.
  typedef struct packed {
    logic              last;
    logic              valid;
    logic [BEAT_W-1:0] data;
  } nbsp_beat_t;

endpackage

`default_nettype wire

### src/nbsp_cell.sv
// One cell of the value table chain: a stored entry and a search token stage.
`default_nettype none

module nbsp_cell import nbsp_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_idx,
  input  wire logic [15:0] wr_val,
  input  wire logic [15:0] sample,
  input  wire logic        tok_in,
  input  wire logic        kill,
  output logic             tok,
  output logic             hit,
  output logic             tok_out
);

  logic [15:0] entry_r;
  logic        tok_r;
  logic        tok_nxt;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) == IDX)) begin
      entry_r <= wr_val;
    end
  end

  assign tok_nxt = kill ? 1'b0 : tok_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // The token stops at the first cell that matches.
  assign tok     = tok_r;
  assign hit     = tok_r && (entry_r == sample);
  assign tok_out = tok_r && !hit;

endmodule

`default_nettype wire

### src/nbsp_pack.sv
// Bit packer: appends codes to a byte stream, low chunk first and each chunk MSB-first, and flushes the partial byte.
`default_nettype none

module nbsp_pack import nbsp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nbsp_pack_cmd_t  cmd,
  output nbsp_pack_res_t       res
);

  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  filled_r, filled_nxt;
  logic [CODE_W-1:0] mask;
  logic [CODE_W-1:0] code_m;
  logic [3:0]  lo_n;
  logic [15:0] seq;
  logic [23:0] acc;
  logic [4:0]  total;
  logic [1:0]  n_bytes;

  always_comb begin
    mask   = CODE_W'((16'd1 << cmd.code_bits) - 16'd1);
    code_m = cmd.code & mask;
    lo_n   = (cmd.code_bits >= 4'd8) ? 4'd8 : cmd.code_bits;
    // Low chunk first, then the upper bits, both left-justified.
    seq    = (16'(code_m[7:0]) << (5'd16 - 5'(lo_n)))
           | (16'(code_m[14:8]) << (5'd16 - 5'(cmd.code_bits)));
    acc    = {partial_r, 16'h0000} | ({seq, 8'h00} >> filled_r);
    total  = 5'(filled_r) + 5'(cmd.code_bits);
    n_bytes = total[4:3];

    res.n_bytes     = cmd.pack_en ? n_bytes : 2'd0;
    res.byte0       = acc[23:16];
    res.byte1       = acc[15:8];
    res.flush_valid = (filled_r != 3'd0);
    res.flush_byte  = (filled_r != 3'd0) ? partial_r : 8'h00;

    partial_nxt = partial_r;
    filled_nxt  = filled_r;
    if (cmd.flush_en) begin
      partial_nxt = 8'h00;
      filled_nxt  = 3'd0;
    end else if (cmd.pack_en) begin
      filled_nxt = total[2:0];
      unique case (n_bytes)
        2'd0:    partial_nxt = acc[23:16];
        2'd1:    partial_nxt = acc[15:8];
        default: partial_nxt = acc[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'h00;
      filled_r  <= 3'd0;
    end else begin
      partial_r <= partial_nxt;
      filled_r  <= filled_nxt;
    end
  end

endmodule

`default_nettype wire

### src/n_bit_sample_packer_core.sv
// Top level of the n-bit sample packer: control, table cell chain, bit packer and output queue.
//
// A sample in copy or shift mode passes through accept, code forming and packing. In table mode
// with a nonzero table_count a search comes between code forming and packing: the search token
// walks the cell chain one cell per cycle up to the matching cell, or through
// min(table_count, TABLE_DEPTH) cells when nothing matches. Table writes and end items leave the
// control in idle. Results go into a four-beat queue; a new item is taken while earlier beats
// wait, as long as two free slots remain. There is no clearing pass after reset.
`default_nettype none

module n_bit_sample_packer_core import nbsp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // value_in[15:0], entry_index[23:16]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tuser,  // byte_valid[0]
  output logic             out_tlast,
  // Configuration.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [1:0]  pack_mode_r;
  logic [4:0]  sample_bits_r;
  logic [3:0]  code_bits_r;
  logic [15:0] offset_r;
  logic [8:0]  table_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_mode_r   <= MODE_COPY;
      sample_bits_r <= 5'd8;
      code_bits_r   <= 4'd8;
      offset_r      <= 16'h0000;
      table_count_r <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PACK_MODE:   pack_mode_r   <= cfg_wdata[1:0];
        REG_SAMPLE_BITS: sample_bits_r <= cfg_wdata[4:0];
        REG_CODE_BITS:   code_bits_r   <= cfg_wdata[3:0];
        REG_OFFSET:      offset_r      <= cfg_wdata;
        REG_TABLE_COUNT: table_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic        in_acc;
  logic [1:0]  in_kind;
  logic [15:0] in_val;
  logic [7:0]  in_idx;
  logic        tbl_we;

  assign in_kind = in_tuser;
  assign in_val  = in_tdata[15:0];
  assign in_idx  = in_tdata[23:16];
  assign in_acc  = in_tvalid && in_tready;
  assign tbl_we  = in_acc && (in_kind == KIND_TABLE) && (32'(in_idx) < TABLE_DEPTH);

  // Control state.
  nbsp_state_t       state_r, state_nxt;
  logic [15:0]       val_r;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              start;
  logic              kill;
  logic [CW-1:0]     lim;
  logic [15:0]       diff;
  logic [4:0]        shamt;
  logic              hit_any;

  logic [2:0] fifo_cnt_r;

  assign in_tready = (state_r == ST_IDLE) && (fifo_cnt_r <= 3'd2);

  always_comb begin
    lim   = (32'(table_count_r) >= TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(table_count_r);
    diff  = val_r - offset_r;
    shamt = (sample_bits_r > 5'(code_bits_r)) ? (sample_bits_r - 5'(code_bits_r)) : 5'd0;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    start     = 1'b0;
    kill      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_SAMPLE)) begin
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        if (pack_mode_r == MODE_TABLE) begin
          if (lim == '0) begin
            code_nxt  = CODE_W'(table_count_r);
            state_nxt = ST_PACK;
          end else begin
            start     = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SEARCH;
          end
        end else if (pack_mode_r == MODE_SHIFT) begin
          code_nxt  = CODE_W'(diff >> shamt);
          state_nxt = ST_PACK;
        end else begin
          code_nxt  = CODE_W'(diff);
          state_nxt = ST_PACK;
        end
      end
      ST_SEARCH: begin
        priority if (hit_any) begin
          code_nxt  = CODE_W'(cnt_r);
          kill      = 1'b1;
          state_nxt = ST_PACK;
        end else if (CW'(cnt_r) == lim - CW'(1)) begin
          code_nxt  = CODE_W'(table_count_r);
          kill      = 1'b1;
          state_nxt = ST_PACK;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_PACK: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r <= in_val;
    end
    code_r <= code_nxt;
  end

  // Table cell chain; the search token enters at cell 0.
  logic [TABLE_DEPTH-1:0] tok_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] pass_vec;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = start;
    end else begin : g_link
      assign tok_in = pass_vec[i-1];
    end
    nbsp_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (tbl_we),
      .wr_idx  (in_idx),
      .wr_val  (in_val),
      .sample  (val_r),
      .tok_in  (tok_in),
      .kill    (kill),
      .tok     (tok_vec[i]),
      .hit     (hit_vec[i]),
      .tok_out (pass_vec[i])
    );
  end

  assign hit_any = |hit_vec;

  // Bit packer.
  nbsp_pack_cmd_t pack_cmd;
  nbsp_pack_res_t pack_res;

  always_comb begin
    pack_cmd.pack_en   = (state_r == ST_PACK);
    pack_cmd.flush_en  = in_acc && (in_kind == KIND_END);
    pack_cmd.code      = code_r;
    pack_cmd.code_bits = code_bits_r;
  end

  nbsp_pack u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pack_cmd),
    .res   (pack_res)
  );

  // Output queue of four beats.
  nbsp_beat_t fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [1:0] push_n;
  nbsp_beat_t beat0, beat1;
  logic       pop;

  always_comb begin
    beat0 = '{last: 1'b0, valid: 1'b1, data: pack_res.byte0};
    beat1 = '{last: 1'b0, valid: 1'b1, data: pack_res.byte1};
    push_n = pack_res.n_bytes;
    if (pack_cmd.flush_en) begin
      beat0  = '{last: 1'b1, valid: pack_res.flush_valid, data: pack_res.flush_byte};
      push_n = 2'd1;
    end
  end

  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= beat0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 2'd0;
      rd_ptr_r   <= 2'd0;
      fifo_cnt_r <= 3'd0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + push_n;
      rd_ptr_r   <= rd_ptr_r + 2'(pop);
      fifo_cnt_r <= fifo_cnt_r + 3'(push_n) - 3'(pop);
    end
  end

  assign out_tvalid = (fifo_cnt_r != 3'd0);
  assign out_tdata  = fifo_r[rd_ptr_r].data;
  assign out_tuser  = fifo_r[rd_ptr_r].valid;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= 3'd4)
    else $error("output queue overflow");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token in the cell chain");

  a_token_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PACK) |-> (tok_vec == '0))
    else $error("search token left in the chain after the search ended");

  a_search_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (fifo_cnt_r <= 3'd2))
    else $error("search running without room for its result beats");
`endif

endmodule

`default_nettype wire
